// ----- hdl/odcm_pkg.sv -----
package odcm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CARRIER_STEP   = 3'd0,
    CFG_CHROMA_STEP    = 3'd1,
    CFG_CHROMA_OFFSET  = 3'd2,
    CFG_LUMA_GAIN      = 3'd3,
    CFG_CHROMA_GAIN    = 3'd4,
    CFG_LEVEL_OFFSET   = 3'd5,
    CFG_BIT_MASK       = 3'd6,
    CFG_WORD_COUNT     = 3'd7
  } odcm_cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [31:0] RST_CARRIER_STEP  = 32'd3288334336;
  localparam logic [31:0] RST_CHROMA_STEP   = 32'd3480509720;
  localparam logic [31:0] RST_CHROMA_OFFSET = 32'd6835652;
  localparam logic [15:0] RST_LUMA_GAIN     = 16'd4096;
  localparam logic [15:0] RST_CHROMA_GAIN   = 16'd0;
  localparam logic [15:0] RST_LEVEL_OFFSET  = 16'd2867;
  localparam logic [31:0] RST_BIT_MASK      = 32'hFFFF_FFFF;
  localparam logic [6:0]  RST_WORD_COUNT    = 7'd51;

  // Carrier start phase (a small epsilon off zero)
  localparam logic [31:0] EPS_PHASE = 32'd6835652;

  // Sample control carried along the pipeline
  typedef struct packed {
    logic       valid;
    logic       neg_c;
    logic       neg_t;
    logic       emit;
    logic       last;
    logic [5:0] widx;
  } odcm_ctl_t;

  // Quarter-wave sine entry in Q1.15, odd-power Taylor series in Q30
  function automatic logic [14:0] quarter_sine(input int unsigned idx, input int tbits);
    longint u;
    longint u2;
    longint p;
    longint s;
    u  = longint'(2 * idx + 1) <<< (29 - tbits);
    u2 = (u * u) >>> 30;
    p  = 172271;
    p  = 5026995 - ((u2 * p) >>> 30);
    p  = 85569306 - ((u2 * p) >>> 30);
    p  = 693598668 - ((u2 * p) >>> 30);
    p  = 1686629713 - ((u2 * p) >>> 30);
    s  = (u * p) >>> 30;
    s  = (s + 16384) >>> 15;
    if (s > 32767) begin
      s = 32767;
    end
    if (s < 0) begin
      s = 0;
    end
    return s[14:0];
  endfunction

endpackage

// ----- hdl/odcm_front.sv -----
module odcm_front import odcm_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int MAX_WORDS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic                       adv,
  input  logic                       restart,
  input  logic [31:0]                carrier_step,
  input  logic [31:0]                chroma_step,
  input  logic [31:0]                chroma_offset,
  input  logic [6:0]                 word_count,
  output odcm_ctl_t                  ctl_o,
  output logic [SINE_TABLE_BITS-1:0] addr_c_o,
  output logic [SINE_TABLE_BITS-1:0] addr_t_o
);

  localparam int CW   = $clog2(MAX_WORDS + 1);
  localparam int CMPW = ((CW > 7) ? CW : 7) + 1;
  localparam int XW   = CW + 6;
  localparam int TB   = SINE_TABLE_BITS;

  logic [31:0]   carrier_phase_r, carrier_phase_nxt;
  logic [31:0]   tone_phase_r, tone_phase_nxt;
  logic          run_done_r, run_done_nxt;
  logic [4:0]    bit_pos_r, bit_pos_nxt;
  logic [CW-1:0] word_cnt_r, word_cnt_nxt;
  odcm_ctl_t     ctl_r, ctl_nxt;
  logic [TB-1:0] addr_c_r, addr_c_nxt;
  logic [TB-1:0] addr_t_r, addr_t_nxt;

  logic [31:0]   cph;
  logic [31:0]   tph;
  logic          done;
  logic [4:0]    bp;
  logic [CW-1:0] wc;
  logic [CMPW-1:0] wc_plus;
  logic [CMPW-1:0] cnt_eff;
  logic [XW-1:0] wc_x;
  logic          emit;
  logic          last;
  logic [TB-1:0] idx_c;
  logic [TB-1:0] idx_t;

  // Restart overrides the stored run state for this sample
  always_comb begin
    cph  = restart ? EPS_PHASE : carrier_phase_r;
    tph  = restart ? chroma_offset : tone_phase_r;
    done = restart ? 1'b0 : run_done_r;
    bp   = restart ? 5'd0 : bit_pos_r;
    wc   = restart ? '0 : word_cnt_r;
  end

  // Clamp the word count and decide the word boundary
  always_comb begin
    wc_plus = CMPW'(wc) + CMPW'(1);
    if (word_count == 7'd0) begin
      cnt_eff = CMPW'(1);
    end else if (CMPW'(word_count) > CMPW'(MAX_WORDS)) begin
      cnt_eff = CMPW'(MAX_WORDS);
    end else begin
      cnt_eff = CMPW'(word_count);
    end
    emit = &bp;
    last = emit && (wc_plus >= cnt_eff);
    wc_x = XW'(wc);
  end

  // Map phases to quarter-table addresses, mirroring odd quadrants
  always_comb begin
    idx_c = cph[29 -: TB];
    idx_t = tph[29 -: TB];
    addr_c_nxt = cph[30] ? ~idx_c : idx_c;
    addr_t_nxt = tph[30] ? ~idx_t : idx_t;
    ctl_nxt.valid = acc && !done;
    ctl_nxt.neg_c = cph[31];
    ctl_nxt.neg_t = tph[31];
    ctl_nxt.emit  = emit;
    ctl_nxt.last  = last;
    ctl_nxt.widx  = wc_x[5:0];
  end

  // Advance run state on an active sample
  always_comb begin
    carrier_phase_nxt = carrier_phase_r;
    tone_phase_nxt    = tone_phase_r;
    run_done_nxt      = run_done_r;
    bit_pos_nxt       = bit_pos_r;
    word_cnt_nxt      = word_cnt_r;
    if (acc && !done) begin
      carrier_phase_nxt = cph + carrier_step;
      tone_phase_nxt    = tph + chroma_step;
      bit_pos_nxt       = bp + 5'd1;
      run_done_nxt      = last;
      word_cnt_nxt      = emit ? CW'(wc_plus) : wc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_phase_r <= EPS_PHASE;
      tone_phase_r    <= RST_CHROMA_OFFSET;
      run_done_r      <= 1'b1;
      bit_pos_r       <= 5'd0;
      word_cnt_r      <= '0;
      ctl_r           <= '0;
    end else begin
      carrier_phase_r <= carrier_phase_nxt;
      tone_phase_r    <= tone_phase_nxt;
      run_done_r      <= run_done_nxt;
      bit_pos_r       <= bit_pos_nxt;
      word_cnt_r      <= word_cnt_nxt;
      if (adv) begin
        ctl_r <= ctl_nxt;
      end
    end
  end

  // Hold the table addresses while the pipeline stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      addr_c_r <= addr_c_nxt;
      addr_t_r <= addr_t_nxt;
    end
  end

  assign ctl_o    = ctl_r;
  assign addr_c_o = addr_c_r;
  assign addr_t_o = addr_t_r;

`ifndef SYNTHESIS
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(carrier_phase_r) && $stable(tone_phase_r))
    else $error("phase moved without an accepted word");
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (run_done_r && !(acc && restart)) |=> run_done_r)
    else $error("run left idle without restart");
  a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.valid && ctl_r.last |-> ctl_r.emit)
    else $error("last flag on a sample that closes no word");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(word_cnt_r) < CMPW'(MAX_WORDS) || run_done_r)
    else $error("word counter beyond the run length");
`endif

endmodule

// ----- hdl/odcm_sine_rom.sv -----
module odcm_sine_rom import odcm_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  odcm_ctl_t                  ctl_i,
  input  logic [SINE_TABLE_BITS-1:0] addr_c,
  input  logic [SINE_TABLE_BITS-1:0] addr_t,
  output odcm_ctl_t                  ctl_o,
  output logic [14:0]                sine_c_o,
  output logic [14:0]                sine_t_o
);

  localparam int DEPTH = 2 ** SINE_TABLE_BITS;

  logic [14:0] rom [DEPTH];
  logic [14:0] sine_c_r;
  logic [14:0] sine_t_r;
  odcm_ctl_t   ctl_r;

  // Fill the quarter-wave table with constants
  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom[g] = quarter_sine(g, SINE_TABLE_BITS);
  end

  // Read both ports, registered
  always_ff @(posedge clk) begin
    if (adv) begin
      sine_c_r <= rom[addr_c];
      sine_t_r <= rom[addr_t];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  assign ctl_o    = ctl_r;
  assign sine_c_o = sine_c_r;
  assign sine_t_o = sine_t_r;

endmodule

// ----- hdl/odcm_back.sv -----
module odcm_back import odcm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  odcm_ctl_t          ctl_i,
  input  logic [14:0]        sine_c,
  input  logic [14:0]        sine_t,
  input  logic signed [15:0] luma_gain,
  input  logic signed [15:0] chroma_gain,
  input  logic signed [15:0] level_offset,
  input  logic [31:0]        bit_mask,
  output logic               stall,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_packed_word,
  output logic [5:0]         out_word_index,
  output logic               out_last
);

  logic signed [15:0] sv_c;
  logic signed [15:0] sv_t;
  logic signed [31:0] prod_c_r, prod_c_nxt;
  logic signed [31:0] prod_t_r, prod_t_nxt;
  odcm_ctl_t          ctl_r;
  logic signed [33:0] sum;
  logic               bit_val;
  logic [31:0]        shift_r, shift_nxt;
  logic               out_valid_r;
  logic [31:0]        word_r;
  logic [5:0]         widx_r;
  logic               last_r;
  logic               adv;

  // Stall only when a finished word meets a full, blocked output
  assign stall = ctl_r.valid && ctl_r.emit && out_valid_r && !out_ready;
  assign adv   = !stall;

  // Apply quadrant sign and weight both tones
  always_comb begin
    sv_c = ctl_i.neg_c ? -$signed({1'b0, sine_c}) : $signed({1'b0, sine_c});
    sv_t = ctl_i.neg_t ? -$signed({1'b0, sine_t}) : $signed({1'b0, sine_t});
    prod_c_nxt = 32'(luma_gain) * 32'(sv_c);
    prod_t_nxt = 32'(chroma_gain) * 32'(sv_t);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_c_r <= prod_c_nxt;
      prod_t_r <= prod_t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  // Sum with the level offset and take the sign decision
  always_comb begin
    sum = 34'(prod_c_r) + 34'(prod_t_r) + (34'(level_offset) <<< 15);
    bit_val = !sum[33] && (sum != '0);
    shift_nxt = {shift_r[30:0], bit_val};
  end

  // Shift samples in, MSB first
  always_ff @(posedge clk) begin
    if (adv && ctl_r.valid) begin
      shift_r <= shift_nxt;
    end
  end

  // Load the output word or drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && ctl_r.valid && ctl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_r.valid && ctl_r.emit) begin
      word_r <= shift_nxt & bit_mask;
      widx_r <= ctl_r.widx;
      last_r <= ctl_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_word = word_r;
  assign out_word_index  = widx_r;
  assign out_last        = last_r;

`ifndef SYNTHESIS
  a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(shift_r) && $stable(prod_c_r) && $stable(ctl_r))
    else $error("pipeline moved during a stall");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(word_r))
    else $error("pending output word overwritten");
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    stall |-> out_valid_r && ctl_r.emit)
    else $error("stall without a blocked word");
`endif

endmodule

// ----- hdl/one_bit_dual_carrier_modulator.sv -----
// Pipeline of 4 stages (phase/address, sine table read, weighting multiply, decision and
//   packing); a word is on out_* once the item that completes it has passed the packing stage.
// Throughput: one item per cycle while in_ready is high; a word every 32 active items.
// in_ready drops only while a finished word waits on a full output register.
// Reset (synchronous, rst_n low): registers take their defaults, run is idle until restart.
module one_bit_dual_carrier_modulator import odcm_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int MAX_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_packed_word,
  output logic [5:0]  out_word_index,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]        carrier_step_r;
  logic [31:0]        chroma_step_r;
  logic [31:0]        chroma_offset_r;
  logic signed [15:0] luma_gain_r;
  logic signed [15:0] chroma_gain_r;
  logic signed [15:0] level_offset_r;
  logic [31:0]        bit_mask_r;
  logic [6:0]         word_count_r;

  logic               stall;
  logic               adv;
  logic               acc;
  odcm_ctl_t          ctl1;
  odcm_ctl_t          ctl2;
  logic [SINE_TABLE_BITS-1:0] addr_c;
  logic [SINE_TABLE_BITS-1:0] addr_t;
  logic [14:0]        sine_c;
  logic [14:0]        sine_t;

  assign adv      = !stall;
  assign in_ready = adv;
  assign acc      = in_valid && adv;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_step_r  <= RST_CARRIER_STEP;
      chroma_step_r   <= RST_CHROMA_STEP;
      chroma_offset_r <= RST_CHROMA_OFFSET;
      luma_gain_r     <= RST_LUMA_GAIN;
      chroma_gain_r   <= RST_CHROMA_GAIN;
      level_offset_r  <= RST_LEVEL_OFFSET;
      bit_mask_r      <= RST_BIT_MASK;
      word_count_r    <= RST_WORD_COUNT;
    end else if (cfg_we) begin
      case (odcm_cfg_idx_t'(cfg_index))
        CFG_CARRIER_STEP:  carrier_step_r  <= cfg_data;
        CFG_CHROMA_STEP:   chroma_step_r   <= cfg_data;
        CFG_CHROMA_OFFSET: chroma_offset_r <= cfg_data;
        CFG_LUMA_GAIN:     luma_gain_r     <= cfg_data[15:0];
        CFG_CHROMA_GAIN:   chroma_gain_r   <= cfg_data[15:0];
        CFG_LEVEL_OFFSET:  level_offset_r  <= cfg_data[15:0];
        CFG_BIT_MASK:      bit_mask_r      <= cfg_data;
        CFG_WORD_COUNT:    word_count_r    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  odcm_front #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .adv          (adv),
    .restart      (in_restart),
    .carrier_step (carrier_step_r),
    .chroma_step  (chroma_step_r),
    .chroma_offset(chroma_offset_r),
    .word_count   (word_count_r),
    .ctl_o        (ctl1),
    .addr_c_o     (addr_c),
    .addr_t_o     (addr_t)
  );

  odcm_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl_i   (ctl1),
    .addr_c  (addr_c),
    .addr_t  (addr_t),
    .ctl_o   (ctl2),
    .sine_c_o(sine_c),
    .sine_t_o(sine_t)
  );

  odcm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl_i          (ctl2),
    .sine_c         (sine_c),
    .sine_t         (sine_t),
    .luma_gain      (luma_gain_r),
    .chroma_gain    (chroma_gain_r),
    .level_offset   (level_offset_r),
    .bit_mask       (bit_mask_r),
    .stall          (stall),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_word(out_packed_word),
    .out_word_index (out_word_index),
    .out_last       (out_last)
  );

endmodule

// ----- tb/odcm_checker.sv -----
`timescale 1ns / 100ps

module odcm_checker import odcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_restart,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_packed_word,
  input  logic [5:0]  out_word_index,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          err_count,
  output int          pending
);

  localparam int TABLE_BITS = 10;
  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int RUN_MAX    = 64;

  typedef struct packed {
    logic [31:0] bits;
    logic [5:0]  index;
    logic        last;
  } word_t;

  // Words still owed by the block, oldest first
  word_t expected_words[$];

  // Quarter-wave sine, Q1.15
  int quarter_wave [TABLE_SIZE];

  // Shadow configuration
  logic [31:0] carrier_inc;
  logic [31:0] tone_inc;
  logic [31:0] tone_start;
  shortint     luma_w;
  shortint     chroma_w;
  shortint     level_bias;
  logic [31:0] word_mask;
  logic [6:0]  run_words;

  // Shadow modulator state
  logic [31:0] carrier_ph;
  logic [31:0] tone_ph;
  logic [31:0] sample_reg;
  logic [4:0]  sample_pos;
  int unsigned words_done;
  logic        run_idle;

  // Odd Taylor series in Q30, evaluated by Horner's rule, rounded to Q1.15
  function automatic int wave_entry(input int unsigned k);
    longint coef [5];
    longint x;
    longint x2;
    longint acc;
    coef = '{172271, 5026995, 85569306, 693598668, 1686629713};
    x = longint'(2 * k + 1) <<< (29 - TABLE_BITS);
    x2 = (x * x) >>> 30;
    acc = coef[0];
    for (int j = 1; j < 5; j++) begin
      acc = coef[j] - ((x2 * acc) >>> 30);
    end
    acc = (((x * acc) >>> 30) + 16384) >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    if (acc < 0) begin
      acc = 0;
    end
    return int'(acc);
  endfunction

  // Fold the phase onto the quarter table: mirror odd quadrants, negate the lower half
  function automatic longint sine_at(input logic [31:0] ph);
    logic [TABLE_BITS-1:0] k;
    longint v;
    k = ph[29 -: TABLE_BITS];
    if (ph[30]) begin
      k = ~k;
    end
    v = quarter_wave[k];
    return ph[31] ? -v : v;
  endfunction

  task automatic reset_shadow();
    carrier_inc = RST_CARRIER_STEP;
    tone_inc    = RST_CHROMA_STEP;
    tone_start  = RST_CHROMA_OFFSET;
    luma_w      = RST_LUMA_GAIN;
    chroma_w    = RST_CHROMA_GAIN;
    level_bias  = RST_LEVEL_OFFSET;
    word_mask   = RST_BIT_MASK;
    run_words   = RST_WORD_COUNT;
    carrier_ph  = EPS_PHASE;
    tone_ph     = RST_CHROMA_OFFSET;
    sample_reg  = '0;
    sample_pos  = '0;
    words_done  = 0;
    run_idle    = 1'b1;
  endtask

  task automatic apply_cfg(input logic [2:0] idx, input logic [31:0] d);
    case (odcm_cfg_idx_t'(idx))
      CFG_CARRIER_STEP:  carrier_inc = d;
      CFG_CHROMA_STEP:   tone_inc = d;
      CFG_CHROMA_OFFSET: tone_start = d;
      CFG_LUMA_GAIN:     luma_w = d[15:0];
      CFG_CHROMA_GAIN:   chroma_w = d[15:0];
      CFG_LEVEL_OFFSET:  level_bias = d[15:0];
      CFG_BIT_MASK:      word_mask = d;
      CFG_WORD_COUNT:    run_words = d[6:0];
      default: ;
    endcase
  endtask

  // One sample tick: decide the bit, advance phases, emit a word every 32 bits
  task automatic predict_tick(input logic restart);
    longint acc;
    int unsigned lim;
    word_t w;
    if (restart) begin
      carrier_ph = EPS_PHASE;
      tone_ph    = tone_start;
      sample_reg = '0;
      sample_pos = '0;
      words_done = 0;
      run_idle   = 1'b0;
    end
    if (!run_idle) begin
      acc = longint'(luma_w) * sine_at(carrier_ph)
          + longint'(chroma_w) * sine_at(tone_ph)
          + longint'(level_bias) * 32768;
      carrier_ph = carrier_ph + carrier_inc;
      tone_ph    = tone_ph + tone_inc;
      sample_reg = {sample_reg[30:0], acc > 0};
      sample_pos = sample_pos + 5'd1;
      if (sample_pos == 5'd0) begin
        lim = run_words;
        if (lim == 0) begin
          lim = 1;
        end
        if (lim > RUN_MAX) begin
          lim = RUN_MAX;
        end
        w.bits  = sample_reg & word_mask;
        w.index = words_done[5:0];
        w.last  = (words_done + 1 >= lim);
        expected_words.push_back(w);
        sample_reg = '0;
        words_done++;
        if (w.last) begin
          run_idle = 1'b1;
        end
      end
    end
  endtask

  initial begin
    for (int k = 0; k < TABLE_SIZE; k++) begin
      quarter_wave[k] = wave_entry(k);
    end
    err_count = 0;
    pending = 0;
    reset_shadow();
  end

  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (!rst_n) begin
      reset_shadow();
      expected_words.delete();
    end else begin
      // Compare each delivered word with the oldest expectation
      if (out_valid && out_ready) begin
        got = '{out_packed_word, out_word_index, out_last};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: got bits %h index %0d last %b",
                   $time, got.bits, got.index, got.last);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.bits !== want.bits || got.index !== want.index
              || got.last !== want.last) begin
            $display("%0t: word mismatch: expected bits %h index %0d last %b, got bits %h index %0d last %b",
                     $time, want.bits, want.index, want.last,
                     got.bits, got.index, got.last);
            err_count++;
          end
        end
      end
      if (cfg_we) begin
        apply_cfg(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        predict_tick(in_restart);
      end
    end
    pending = expected_words.size();
  end

endmodule

// ----- tb/one_bit_dual_carrier_modulator_tb.sv -----
`timescale 1ns / 100ps

module one_bit_dual_carrier_modulator_tb;
  import odcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 850;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_packed_word;
  logic [5:0]  out_word_index;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int err_count;
  int pending;
  int idle_run = 0;
  int random_items = 0;
  int phase_no = 0;
  bit calm = 1'b0;
  bit stall_req = 1'b0;

  one_bit_dual_carrier_modulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_packed_word(out_packed_word), .out_word_index(out_word_index),
    .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  odcm_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_packed_word(out_packed_word), .out_word_index(out_word_index),
    .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .err_count(err_count), .pending(pending)
  );

  always #10 clk = ~clk;

  // Count cycles without any handshake
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      idle_run++;
    end else begin
      idle_run = 0;
    end
  end

  // Mostly short gaps, a few long ones; none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return $urandom();
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int g;
    forever begin
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  task automatic write_reg(input odcm_cfg_idx_t idx, input logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // Write the whole register set; narrow registers get junk in the unused bits
  task automatic load_settings(input logic [31:0] cstep, input logic [31:0] tstep,
                               input logic [31:0] toff, input logic [15:0] lg,
                               input logic [15:0] cg, input logic [15:0] lv,
                               input logic [31:0] msk, input logic [6:0] wc);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(CFG_CARRIER_STEP, cstep);
    write_reg(CFG_CHROMA_STEP, tstep);
    write_reg(CFG_CHROMA_OFFSET, toff);
    write_reg(CFG_LUMA_GAIN, {junk[31:16], lg});
    write_reg(CFG_CHROMA_GAIN, {junk[15:0], cg});
    write_reg(CFG_LEVEL_OFFSET, {junk[23:8], lv});
    write_reg(CFG_BIT_MASK, msk);
    write_reg(CFG_WORD_COUNT, {junk[31:7], wc});
    cfg_we <= 1'b0;
  endtask

  // Offer one tick and hold it until accepted
  task automatic send_tick(input logic restart);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom_range(0, 1));
      repeat (g) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send n ticks; the first carries restart_first, tick restart_at restarts the run
  task automatic drive_run(input int n, input logic restart_first, input int restart_at);
    for (int i = 0; i < n; i++) begin
      send_tick((i == 0) ? restart_first : (i == restart_at));
    end
  endtask

  // Stop offering, let every owed word arrive and the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase();
    int r;
    int wc_eff;
    int n;
    int at;
    logic [6:0] wc;
    logic first;
    settle();
    r = $urandom_range(0, 99);
    if (phase_no == 3) begin
      wc = 7'd127;
    end else if (r < 8) begin
      wc = 7'd0;
    end else if (r < 40) begin
      wc = 7'd1;
    end else if (r < 70) begin
      wc = 7'd2;
    end else if (r < 90) begin
      wc = 7'd3;
    end else if (r < 98) begin
      wc = 7'($urandom_range(4, 8));
    end else begin
      wc = 7'($urandom_range(64, 127));
    end
    wc_eff = (wc == 0) ? 1 : ((wc > 64) ? 64 : wc);
    n = wc_eff * 32;
    at = -1;
    r = $urandom_range(0, 99);
    if (wc_eff > 8) begin
      // long run: stop after a few words, a later phase may pick it up
      n = $urandom_range(32, 160);
    end else if (r < 12) begin
      // broken run: stop mid-way, a later phase may pick it up
      n = $urandom_range(1, n - 1);
    end else if (r < 24) begin
      // restart somewhere inside the run
      at = $urandom_range(1, (n - 1 < 100) ? n - 1 : 100);
      n = at + wc_eff * 32;
    end
    first = ($urandom_range(0, 4) != 0);
    load_settings(rand32(), rand32(), rand32(), rand16(), rand16(), rand16(),
                  pick_mask(), wc);
    calm = ($urandom_range(0, 4) == 0);
    drive_run(n, first, at);
    random_items += n;
    if ($urandom_range(0, 3) == 0) begin
      drive_run($urandom_range(1, 4), 1'b0, -1);
    end
    phase_no++;
  endtask

  // Watchdog
  initial begin
    wait (rst_n);
    while (idle_run < WATCHDOG_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle after reset: ticks without restart are dropped
    drive_run(2, 1'b0, -1);

    // Reset settings with a word count of zero, taken as one
    settle();
    load_settings(RST_CARRIER_STEP, RST_CHROMA_STEP, RST_CHROMA_OFFSET, RST_LUMA_GAIN,
                  RST_CHROMA_GAIN, RST_LEVEL_OFFSET, RST_BIT_MASK, 7'd0);
    drive_run(32, 1'b1, -1);
    drive_run(2, 1'b0, -1);

    // Top extremes
    settle();
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 32'hFFFF_FFFF, 7'd1);
    drive_run(32, 1'b1, -1);

    // Bottom extremes, mask cleared
    settle();
    load_settings(32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 32'h0, 7'd2);
    drive_run(64, 1'b1, -1);

    // Zero sum gives a zero bit; restart inside the run
    settle();
    load_settings(RST_CARRIER_STEP, RST_CHROMA_STEP, RST_CHROMA_OFFSET, 16'h0, 16'h0,
                  16'h0, 32'hA5A5_5A5A, 7'd2);
    drive_run(40 + 64, 1'b1, 40);

    // Word count lowered mid-run; a new tone offset waits for restart
    settle();
    load_settings(RST_CARRIER_STEP, RST_CHROMA_STEP, 32'h4000_0000, 16'd4096, 16'd2048,
                  16'd0, RST_BIT_MASK, 7'd3);
    drive_run(40, 1'b1, -1);
    settle();
    load_settings(RST_CARRIER_STEP, RST_CHROMA_STEP, 32'hC000_0000, 16'd4096, 16'd2048,
                  16'd0, RST_BIT_MASK, 7'd1);
    drive_run(24, 1'b0, -1);
    drive_run(2, 1'b0, -1);

    // Long receiver hold-off while ticks keep coming, then pause until drained
    settle();
    load_settings(RST_CARRIER_STEP, RST_CHROMA_STEP, RST_CHROMA_OFFSET, RST_LUMA_GAIN,
                  16'd1500, RST_LEVEL_OFFSET, RST_BIT_MASK, 7'd8);
    calm = 1'b1;
    stall_req = 1'b1;
    drive_run(256, 1'b1, -1);
    calm = 1'b0;

    // Random phases
    while (random_items < RANDOM_ITEMS) begin
      random_phase();
    end

    settle();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/odcm_pkg.sv
hdl/odcm_front.sv
hdl/odcm_sine_rom.sv
hdl/odcm_back.sv
hdl/one_bit_dual_carrier_modulator.sv
tb/odcm_checker.sv
tb/one_bit_dual_carrier_modulator_tb.sv
